### rtl/core/kf2_pkg.sv
// Package for the two-state Kalman filter: register indexes, opcodes, control structs.
// No dependencies.
package kf2_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_REGS        = 6;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_TRANSITION_ROW0    = 3'd0,
        REG_TRANSITION_ROW1    = 3'd1,
        REG_INPUT_GAINS        = 3'd2,
        REG_PROCESS_NOISE_ROW0 = 3'd3,
        REG_PROCESS_NOISE_ROW1 = 3'd4,
        REG_MEASUREMENT_NOISE  = 3'd5
    } reg_index_t;

    // ALU operations of the datapath
    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,   // dst = fmul(a, b)
        OP_ADD  = 3'd1,   // dst = fadd(a, b)
        OP_SUB  = 3'd2,   // dst = fadd(a, -b)
        OP_DIV  = 3'd3,   // dst = fdiv(a, b), multi-cycle
        OP_NZ   = 3'd4,   // dst = a, or one LSB when a is zero
        OP_NEG  = 3'd5    // dst = sat(-a)
    } op_t;

    // Operand / destination slots of the register file
    typedef enum logic [4:0] {
        R_A00 = 5'd0, R_A01 = 5'd1, R_A10 = 5'd2, R_A11 = 5'd3,
        R_B0  = 5'd4, R_B1  = 5'd5,
        R_V00 = 5'd6, R_V01 = 5'd7, R_V10 = 5'd8, R_V11 = 5'd9,
        R_W   = 5'd10,
        R_X0  = 5'd11, R_X1 = 5'd12,
        R_P00 = 5'd13, R_P01 = 5'd14, R_P10 = 5'd15, R_P11 = 5'd16,
        R_Y   = 5'd17, R_U  = 5'd18,
        R_T0  = 5'd19, R_T1 = 5'd20, R_T2 = 5'd21, R_T3 = 5'd22,
        R_T4  = 5'd23, R_T5 = 5'd24, R_T6 = 5'd25, R_T7 = 5'd26,
        R_T8  = 5'd27, R_T9 = 5'd28, R_ONE = 5'd29, R_ZERO = 5'd30,
        R_T10 = 5'd31
    } slot_t;

    typedef struct packed {
        logic  start;    // launch one operation
        op_t   op;
        slot_t src_a;
        slot_t src_b;
        slot_t dst;
        logic  load;     // capture the input transaction
    } kf2_cmd_t;

    typedef struct packed {
        logic done;      // operation written back
    } kf2_status_t;

    typedef struct packed {
        op_t   op;
        slot_t a;
        slot_t b;
        slot_t d;
    } micro_t;

    localparam int PROG_LEN = 40;
    localparam int PC_WIDTH = 6;

    // First half of the microprogram of one filter step
    function automatic micro_t prog(input logic [PC_WIDTH-1:0] pc);
        micro_t m;
        m = '{OP_ADD, R_ZERO, R_ZERO, R_T10};
        case (pc)
            6'd0:  m = '{OP_MUL, R_A01, R_X1,  R_T0};
            6'd1:  m = '{OP_MUL, R_A00, R_X0,  R_T1};
            6'd2:  m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd3:  m = '{OP_MUL, R_B0,  R_U,   R_T1};
            6'd4:  m = '{OP_ADD, R_T0,  R_T1,  R_T8};   // xp0
            6'd5:  m = '{OP_MUL, R_A11, R_X1,  R_T0};
            6'd6:  m = '{OP_MUL, R_A10, R_X0,  R_T1};
            6'd7:  m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd8:  m = '{OP_MUL, R_B1,  R_U,   R_T1};
            6'd9:  m = '{OP_ADD, R_T0,  R_T1,  R_T9};   // xp1
            // ape = A * Pe
            6'd10: m = '{OP_MUL, R_A00, R_P00, R_T0};
            6'd11: m = '{OP_MUL, R_A01, R_P10, R_T1};
            6'd12: m = '{OP_ADD, R_T0,  R_T1,  R_T2};   // ape00
            6'd13: m = '{OP_MUL, R_A00, R_P01, R_T0};
            6'd14: m = '{OP_MUL, R_A01, R_P11, R_T1};
            6'd15: m = '{OP_ADD, R_T0,  R_T1,  R_T3};   // ape01
            6'd16: m = '{OP_MUL, R_A10, R_P00, R_T0};
            6'd17: m = '{OP_MUL, R_A11, R_P10, R_T1};
            6'd18: m = '{OP_ADD, R_T0,  R_T1,  R_T4};   // ape10
            6'd19: m = '{OP_MUL, R_A10, R_P01, R_T0};
            6'd20: m = '{OP_MUL, R_A11, R_P11, R_T1};
            6'd21: m = '{OP_ADD, R_T0,  R_T1,  R_T5};   // ape11
            // pp = ape * A^T + V
            6'd22: m = '{OP_MUL, R_T2,  R_A00, R_T0};
            6'd23: m = '{OP_MUL, R_T3,  R_A01, R_T1};
            6'd24: m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd25: m = '{OP_ADD, R_T0,  R_V00, R_P00};  // pp00
            6'd26: m = '{OP_MUL, R_T2,  R_A10, R_T0};
            6'd27: m = '{OP_MUL, R_T3,  R_A11, R_T1};
            6'd28: m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd29: m = '{OP_ADD, R_T0,  R_V01, R_P01};  // pp01
            6'd30: m = '{OP_MUL, R_T4,  R_A00, R_T0};
            6'd31: m = '{OP_MUL, R_T5,  R_A01, R_T1};
            6'd32: m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd33: m = '{OP_ADD, R_T0,  R_V10, R_P10};  // pp10
            6'd34: m = '{OP_MUL, R_T4,  R_A10, R_T0};
            6'd35: m = '{OP_MUL, R_T5,  R_A11, R_T1};
            6'd36: m = '{OP_ADD, R_T0,  R_T1,  R_T0};
            6'd37: m = '{OP_ADD, R_T0,  R_V11, R_P11};  // pp11
            6'd38: m = '{OP_SUB, R_Y,   R_T8,  R_T6};   // e
            6'd39: m = '{OP_ADD, R_P00, R_W,   R_T7};   // s
            default: m = '{OP_ADD, R_ZERO, R_ZERO, R_T10};
        endcase
        return m;
    endfunction

    localparam int PROG2_LEN = 20;

    function automatic micro_t prog2(input logic [PC_WIDTH-1:0] pc);
        micro_t m;
        m = '{OP_ADD, R_ZERO, R_ZERO, R_T10};
        case (pc)
            6'd0:  m = '{OP_NZ,  R_T7,  R_ZERO, R_T7};
            6'd1:  m = '{OP_DIV, R_P00, R_T7,  R_T4};   // k0
            6'd2:  m = '{OP_DIV, R_P10, R_T7,  R_T5};   // k1
            6'd3:  m = '{OP_MUL, R_T4,  R_T6,  R_T0};
            6'd4:  m = '{OP_ADD, R_T8,  R_T0,  R_X0};
            6'd5:  m = '{OP_MUL, R_T5,  R_T6,  R_T0};
            6'd6:  m = '{OP_ADD, R_T9,  R_T0,  R_X1};
            6'd7:  m = '{OP_SUB, R_ONE, R_T4,  R_T2};   // m00
            6'd8:  m = '{OP_NEG, R_T5,  R_ZERO, R_T3};  // m10
            // new Pe = M * pp; m01 is zero, m11 is one
            6'd9:  m = '{OP_MUL, R_T2,  R_P00, R_T0};
            6'd10: m = '{OP_MUL, R_T2,  R_P01, R_T1};
            6'd11: m = '{OP_MUL, R_T3,  R_P00, R_T6};
            6'd12: m = '{OP_MUL, R_ONE, R_P10, R_T7};
            6'd13: m = '{OP_ADD, R_T6,  R_T7,  R_T8};   // pe10
            6'd14: m = '{OP_MUL, R_T3,  R_P01, R_T6};
            6'd15: m = '{OP_MUL, R_ONE, R_P11, R_T7};
            6'd16: m = '{OP_ADD, R_T6,  R_T7,  R_P11};  // pe11
            6'd17: m = '{OP_ADD, R_T8,  R_ZERO, R_P10};
            6'd18: m = '{OP_ADD, R_T0,  R_ZERO, R_P00}; // pe00
            6'd19: m = '{OP_ADD, R_T1,  R_ZERO, R_P01}; // pe01
            default: m = '{OP_ADD, R_ZERO, R_ZERO, R_T10};
        endcase
        return m;
    endfunction

endpackage

### rtl/core/kf2_if.sv
// Valid/ready channel interfaces for the two-state Kalman filter.
// Depends on nothing.
interface kf2_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_sample;
    logic signed [31:0] previous_drive;
    modport source (output valid, position_sample, previous_drive, input ready);
    modport sink   (input valid, position_sample, previous_drive, output ready);
endinterface

interface kf2_estimate_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    modport source (output valid, position_estimate, velocity_estimate, input ready);
    modport sink   (input valid, position_estimate, velocity_estimate, output ready);
endinterface

interface kf2_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/kalman_filter_two_state_top.sv
// Top level of the two-state Kalman filter with a scalar position measurement.
// Depends on kf2_pkg, kf2_if, kf2_ctrl and kf2_datapath.
//
// Channels: samples (position_sample, previous_drive) enter on a valid/ready
// channel; each accepted transaction yields one estimate transaction
// (position_estimate, velocity_estimate). Coefficients are written on the cfg
// channel (index 0..5, 64-bit data); writes are always taken, unknown indexes
// are dropped. Write only while the filter is idle.
// One item runs a 60-step microprogram over one shared multiplier, an adder and
// a bit-serial divider for the gain terms. One item is processed at a time.
// Reset: estimates and covariance clear to zero, A resets to identity, the
// other coefficients to zero. The estimate is held with valid high until the
// receiver takes it; no new sample is accepted until then.
module kalman_filter_two_state_top #(
    parameter int WORD_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    kf2_sample_if.sink     sample,
    kf2_estimate_if.source estimate,
    kf2_cfg_if.sink        cfg
);
    import kf2_pkg::*;

    kf2_cmd_t              cmd;
    kf2_status_t           status;
    logic [WORD_WIDTH-1:0] x0, x1;

    kf2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (estimate.valid),
        .out_ready (estimate.ready),
        .cmd       (cmd),
        .status    (status)
    );

    kf2_datapath #(
        .WORD_WIDTH    (WORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_y      (sample.position_sample),
        .in_u      (sample.previous_drive),
        .x0        (x0),
        .x1        (x1)
    );

    assign cfg.ready = 1'b1;
    assign estimate.position_estimate = 32'($signed(x0));
    assign estimate.velocity_estimate = 32'($signed(x1));

endmodule

### rtl/core/kf2_datapath.sv
// Datapath: register file, shared multiplier/adder and a restoring divider.
// Depends on kf2_pkg.
module kf2_datapath #(
    parameter int WORD_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kf2_pkg::kf2_cmd_t      cmd,
    output kf2_pkg::kf2_status_t   status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic [31:0]            in_y,
    input  logic [31:0]            in_u,
    output logic [WORD_WIDTH-1:0]  x0,
    output logic [WORD_WIDTH-1:0]  x1
);
    import kf2_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = W + FRACTION_BITS + 1;   // divider numerator magnitude
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    // A00 and A11 come out of reset as the raw word 0x00010000
    localparam logic signed [W-1:0] A_DIAG_RESET = W'(32'h0001_0000);
    localparam logic signed [W-1:0] ONE_Q =
        (FRACTION_BITS >= W - 1) ? WMAX : W'(1 << FRACTION_BITS);

    logic signed [W-1:0] rf_reg [32];
    logic signed [W-1:0] a, b;

    // Multiply stage registers
    logic                 mul_busy_reg;
    logic signed [PW-1:0] prod_reg;
    slot_t                mul_dst_reg;

    // Divider state
    logic                 div_busy_reg;
    logic [NW-1:0]        div_q_reg;
    logic [W:0]           div_rem_reg;
    logic [W-1:0]         div_den_reg;
    logic                 div_neg_reg;
    logic [CW-1:0]        div_cnt_reg;
    slot_t                div_dst_reg;

    assign a = rf_reg[cmd.src_a];
    assign b = rf_reg[cmd.src_b];

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW+1:0] v);
        if (v > PW'(WMAX)) return WMAX;
        if (v < $signed({{(PW+2-W){1'b1}}, WMIN})) return WMIN;
        return v[W-1:0];
    endfunction

    // Combinational results of add, subtract, nonzero and negate
    logic signed [W:0]    sum;
    logic signed [W-1:0]  alu_res;
    logic                 alu_wr;
    always_comb
    begin
        sum     = '0;
        alu_res = '0;
        alu_wr  = 1'b0;
        case (cmd.op)
            OP_ADD:
            begin
                sum = {a[W-1], a} + {b[W-1], b};
                alu_res = sat_w((PW+2)'(sum));
                alu_wr = cmd.start;
            end
            OP_SUB:
            begin
                sum = {a[W-1], a} - {b[W-1], b};
                alu_res = sat_w((PW+2)'(sum));
                alu_wr = cmd.start;
            end
            OP_NZ:
            begin
                alu_res = (a == '0) ? W'(1) : a;
                alu_wr = cmd.start;
            end
            OP_NEG:
            begin
                sum = -{a[W-1], a};
                alu_res = sat_w((PW+2)'(sum));
                alu_wr = cmd.start;
            end
            default:
            begin
                alu_res = '0;
                alu_wr  = 1'b0;
            end
        endcase
    end

    // Rounded, shifted, saturated product
    logic signed [PW+1:0] mul_round;
    logic signed [W-1:0]  mul_res;
    always_comb
    begin
        mul_round = ((PW+2)'(prod_reg) + (PW+2)'(1 << (FRACTION_BITS - 1)))
                    >>> FRACTION_BITS;
        mul_res   = sat_w(mul_round);
    end

    // Divider step: restoring, one quotient bit a cycle on magnitudes
    logic [W:0]      trial;
    logic [W:0]      rem_sh;
    logic [NW-1:0]   q_sh;
    logic [NW:0]     q_signed;
    logic signed [W-1:0] div_res;
    always_comb
    begin
        rem_sh = {div_rem_reg[W-1:0], div_q_reg[NW-1]};
        trial  = rem_sh - {1'b0, div_den_reg};
        q_sh   = {div_q_reg[NW-2:0], ~trial[W]};
        q_signed = div_neg_reg ? -{1'b0, div_q_reg} : {1'b0, div_q_reg};
        if (!div_neg_reg && div_q_reg > NW'(WMAX))
            div_res = WMAX;
        else if (div_neg_reg && div_q_reg > NW'({1'b0, WMAX}) + NW'(1))
            div_res = WMIN;
        else
            div_res = q_signed[W-1:0];
    end

    logic [W-1:0] a_mag, b_mag;
    assign a_mag = a[W-1] ? W'(-a) : W'(a);
    assign b_mag = b[W-1] ? W'(-b) : W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            prod_reg     <= '0;
            mul_dst_reg  <= R_ZERO;
            div_busy_reg <= 1'b0;
            div_q_reg    <= '0;
            div_rem_reg  <= '0;
            div_den_reg  <= '0;
            div_neg_reg  <= 1'b0;
            div_cnt_reg  <= '0;
            div_dst_reg  <= R_ZERO;
            for (int i = 0; i < 32; i++)
            begin
                if (i == int'(R_A00) || i == int'(R_A11))
                    rf_reg[i] <= A_DIAG_RESET;
                else if (i == int'(R_ONE))
                    rf_reg[i] <= ONE_Q;
                else
                    rf_reg[i] <= '0;
            end
        end
        else
        begin
            mul_busy_reg <= cmd.start && (cmd.op == OP_MUL);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRANSITION_ROW0:
                    begin
                        rf_reg[R_A00] <= cfg_data[32 +: W];
                        rf_reg[R_A01] <= cfg_data[0 +: W];
                    end
                    REG_TRANSITION_ROW1:
                    begin
                        rf_reg[R_A10] <= cfg_data[32 +: W];
                        rf_reg[R_A11] <= cfg_data[0 +: W];
                    end
                    REG_INPUT_GAINS:
                    begin
                        rf_reg[R_B0] <= cfg_data[32 +: W];
                        rf_reg[R_B1] <= cfg_data[0 +: W];
                    end
                    REG_PROCESS_NOISE_ROW0:
                    begin
                        rf_reg[R_V00] <= cfg_data[32 +: W];
                        rf_reg[R_V01] <= cfg_data[0 +: W];
                    end
                    REG_PROCESS_NOISE_ROW1:
                    begin
                        rf_reg[R_V10] <= cfg_data[32 +: W];
                        rf_reg[R_V11] <= cfg_data[0 +: W];
                    end
                    REG_MEASUREMENT_NOISE:
                        rf_reg[R_W] <= cfg_data[0 +: W];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                rf_reg[R_Y] <= in_y[W-1:0];
                rf_reg[R_U] <= in_u[W-1:0];
            end
            if (alu_wr)
                rf_reg[cmd.dst] <= alu_res;
            if (cmd.start && cmd.op == OP_MUL)
            begin
                prod_reg     <= a * b;
                mul_dst_reg  <= cmd.dst;
            end
            if (mul_busy_reg)
                rf_reg[mul_dst_reg] <= mul_res;
            if (cmd.start && cmd.op == OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_q_reg    <= NW'(a_mag) << FRACTION_BITS;
                div_rem_reg  <= '0;
                div_den_reg  <= b_mag;
                div_neg_reg  <= a[W-1] ^ b[W-1];
                div_cnt_reg  <= CW'(NW);
                div_dst_reg  <= cmd.dst;
            end
            else if (div_busy_reg)
            begin
                if (div_cnt_reg == '0)
                begin
                    div_busy_reg <= 1'b0;
                    rf_reg[div_dst_reg] <= div_res;
                end
                else
                begin
                    div_rem_reg <= trial[W] ? rem_sh : trial;
                    div_q_reg   <= q_sh;
                    div_cnt_reg <= div_cnt_reg - CW'(1);
                end
            end
        end
    end

    assign status.done = mul_busy_reg || (div_busy_reg && div_cnt_reg == '0) ||
                         (alu_wr);
    assign x0 = rf_reg[R_X0];
    assign x1 = rf_reg[R_X1];

endmodule

### rtl/core/kf2_ctrl.sv
// Controller: sequences the microprogram over the datapath, drives the handshakes.
// Depends on kf2_pkg.
module kf2_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kf2_pkg::kf2_cmd_t    cmd,
    input  kf2_pkg::kf2_status_t status
);
    import kf2_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_NEXT  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [PC_WIDTH-1:0]  pc_reg, pc_next;
    logic                 phase_reg, phase_next;   // second program half
    micro_t               m;

    assign m = phase_reg ? prog2(pc_reg) : prog(pc_reg);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        cmd        = '{1'b0, m.op, m.a, m.b, m.d, 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pc_next    = '0;
                    phase_next = 1'b0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
                if (m.op == OP_ADD || m.op == OP_SUB || m.op == OP_NZ || m.op == OP_NEG)
                    state_next = S_NEXT;
            end
            S_WAIT:
            begin
                if (status.done)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = S_ISSUE;
                if (!phase_reg && pc_reg == PC_WIDTH'(PROG_LEN - 1))
                begin
                    phase_next = 1'b1;
                    pc_next    = '0;
                end
                else if (phase_reg && pc_reg == PC_WIDTH'(PROG2_LEN - 1))
                    state_next = S_OUT;
                else
                    pc_next = pc_reg + PC_WIDTH'(1);
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

### rtl/core/kf2_checker.sv
// Port-level checker for the two-state Kalman filter, bound to the top level.
// Depends on kalman_filter_two_state_top.
module kf2_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] pos
);
    // Never take a sample while an estimate is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("sample taken while estimate pending");

    // An estimate is not offered right after a sample is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("estimate too early");

    // Once delivered, the filter is ready again
    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("not ready after delivery");

    // Pending estimate holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos)))
        else $error("estimate dropped");
endmodule

bind kalman_filter_two_state_top kf2_checker u_kf2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (estimate.valid),
    .out_ready (estimate.ready),
    .pos       (estimate.position_estimate)
);

### tb/kf2_estimate_checker.sv
// Checker for the two-state Kalman filter: predicts each estimate from accepted
// samples and coefficient writes, and compares. Depends on kf2_pkg and kf2_if.
module kf2_estimate_checker
    import kf2_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    kf2_sample_if.sink     sample,
    kf2_estimate_if.sink   estimate,
    kf2_cfg_if.sink        cfg,
    output int             errors,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    logic [63:0] coef [NUM_REGS];
    longint pos_est, vel_est;
    longint cov [4];
    logic [31:0] exp_pos_q [$];
    logic [31:0] exp_vel_q [$];

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd32768;
        return clamp_word(p >>> 16);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint num;
        num = n * 64'sd65536;
        return clamp_word(num / d);
    endfunction

    function automatic longint word_of(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    task automatic mat2_mul(input longint a [4], input longint b [4], output longint r [4]);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                r[i*2+j] = qadd(qmul(a[i*2], b[j]), qmul(a[i*2+1], b[2+j]));
    endtask

    task automatic filter_step(input logic [31:0] y_raw, input logic [31:0] u_raw);
        longint a [4], at [4], vn [4], ape [4], apeat [4], pp [4], m [4], nc [4];
        longint b0, b1, w, y, u, xp0, xp1, e, s, k0, k1;
        a[0] = word_of(coef[REG_TRANSITION_ROW0][63:32]);
        a[1] = word_of(coef[REG_TRANSITION_ROW0][31:0]);
        a[2] = word_of(coef[REG_TRANSITION_ROW1][63:32]);
        a[3] = word_of(coef[REG_TRANSITION_ROW1][31:0]);
        b0 = word_of(coef[REG_INPUT_GAINS][63:32]);
        b1 = word_of(coef[REG_INPUT_GAINS][31:0]);
        vn[0] = word_of(coef[REG_PROCESS_NOISE_ROW0][63:32]);
        vn[1] = word_of(coef[REG_PROCESS_NOISE_ROW0][31:0]);
        vn[2] = word_of(coef[REG_PROCESS_NOISE_ROW1][63:32]);
        vn[3] = word_of(coef[REG_PROCESS_NOISE_ROW1][31:0]);
        w = word_of(coef[REG_MEASUREMENT_NOISE][31:0]);
        y = word_of(y_raw);
        u = word_of(u_raw);
        xp0 = qadd(qadd(qmul(a[1], vel_est), qmul(a[0], pos_est)), qmul(b0, u));
        xp1 = qadd(qadd(qmul(a[3], vel_est), qmul(a[2], pos_est)), qmul(b1, u));
        at[0] = a[0]; at[1] = a[2]; at[2] = a[1]; at[3] = a[3];
        mat2_mul(a, cov, ape);
        mat2_mul(ape, at, apeat);
        for (int i = 0; i < 4; i++) pp[i] = qadd(apeat[i], vn[i]);
        e = qadd(y, -xp0);
        s = qadd(pp[0], w);
        // zero innovation variance falls back to one LSB
        if (s == 0) s = 1;
        k0 = qdiv(pp[0], s);
        k1 = qdiv(pp[2], s);
        pos_est = qadd(xp0, qmul(k0, e));
        vel_est = qadd(xp1, qmul(k1, e));
        m[0] = qadd(64'sd65536, -k0);
        m[1] = 0;
        m[2] = clamp_word(-k1);
        m[3] = 64'sd65536;
        mat2_mul(m, pp, nc);
        cov = nc;
        exp_pos_q.push_back(pos_est[31:0]);
        exp_vel_q.push_back(vel_est[31:0]);
    endtask

    assign pending = exp_pos_q.size();

    always @(posedge clk or negedge rst_n) begin
        logic [31:0] ep, ev;
        int bad;
        if (!rst_n) begin
            coef[0] = 64'h0001_0000_0000_0000;
            coef[1] = 64'h0000_0000_0001_0000;
            for (int i = 2; i < NUM_REGS; i++) coef[i] = '0;
            pos_est = 0;
            vel_est = 0;
            for (int i = 0; i < 4; i++) cov[i] = 0;
            exp_pos_q.delete();
            exp_vel_q.delete();
            errors <= 0;
        end
        else begin
            bad = 0;
            if (cfg.valid && cfg.ready && cfg.index < NUM_REGS)
                coef[cfg.index] = cfg.data;
            if (estimate.valid && estimate.ready) begin
                if (exp_pos_q.size() == 0) begin
                    $error("estimate transaction with no sample pending");
                    bad++;
                end
                else begin
                    ep = exp_pos_q.pop_front();
                    ev = exp_vel_q.pop_front();
                    if (estimate.position_estimate !== ep) begin
                        $error("position_estimate: expected %h, got %h", ep,
                               estimate.position_estimate);
                        bad++;
                    end
                    if (estimate.velocity_estimate !== ev) begin
                        $error("velocity_estimate: expected %h, got %h", ev,
                               estimate.velocity_estimate);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            if (sample.valid && sample.ready)
                filter_step(sample.position_sample, sample.previous_drive);
        end
    end
endmodule

### tb/testbench.sv
// Top of the two-state Kalman filter testbench: clock, reset, stimulus, verdict.
// Depends on kf2_pkg, kf2_if, kf2_estimate_checker and the filter RTL.
module testbench;
    import kf2_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    int   idle_cycles;

    kf2_sample_if   sample ();
    kf2_estimate_if estimate ();
    kf2_cfg_if      cfg ();

    kalman_filter_two_state_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample.sink),
        .estimate (estimate.source),
        .cfg      (cfg.sink)
    );

    kf2_estimate_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample.sink),
        .estimate (estimate.sink),
        .cfg      (cfg.sink),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            estimate.ready <= 1'b0;
        else
            estimate.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (estimate.valid && estimate.ready)
            || (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high after the transaction; the caller drops it when done
    task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    // valid stays high after the transaction; it drops on idle cycles or at drain
    task automatic send_sample(input logic [31:0] y, input logic [31:0] u);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid           <= 1'b1;
        sample.position_sample <= y;
        sample.previous_drive  <= u;
        @(posedge clk);
        while (!sample.ready) @(posedge clk);
    endtask

    task automatic drain_results();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Q16.16 value near the given magnitude scale, random sign
    function automatic logic [31:0] rand_q(int bits);
        logic [31:0] v;
        v = $urandom() & ((32'h1 << bits) - 1);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic load_coefs(input logic [63:0] r0, input logic [63:0] r1,
                              input logic [63:0] bg, input logic [63:0] n0,
                              input logic [63:0] n1, input logic [63:0] wn);
        drain_results();
        write_reg(REG_TRANSITION_ROW0, r0);
        write_reg(REG_TRANSITION_ROW1, r1);
        write_reg(REG_INPUT_GAINS, bg);
        write_reg(REG_PROCESS_NOISE_ROW0, n0);
        write_reg(REG_PROCESS_NOISE_ROW1, n1);
        write_reg(REG_MEASUREMENT_NOISE, wn);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_block(input int count, input int bits);
        for (int i = 0; i < count; i++)
            send_sample(($urandom_range(9) == 0) ? $urandom() : rand_q(bits),
                        ($urandom_range(9) == 0) ? $urandom() : rand_q(bits));
    endtask

    initial
    begin
        int pause;
        rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sample.valid = 1'b0;
        sample.position_sample = '0;
        sample.previous_drive = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_TRANSITION_ROW0;
        cfg.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: zero noise, so S hits zero and clamps to one LSB
        send_sample(32'h7fff_ffff, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7fff_ffff);
        send_sample(32'h0000_0000, 32'hffff_ffff);
        send_sample(32'hffff_ffff, 32'h0000_0000);
        send_sample(32'h0001_0000, 32'h0001_0000);

        // constant-velocity model with noise; then extremes everywhere
        load_coefs(64'h0001_0000_0000_0100, 64'h0000_0000_0001_0000,
                   64'h0000_0000_0000_0100, 64'h0000_0100_0000_0000,
                   64'h0000_0000_0000_0100, 64'h0000_0000_0001_0000);
        send_sample(32'h0002_0000, 32'h0000_8000);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff);
        send_sample(32'h8000_0000, 32'h8000_0000);
        load_coefs(64'h7fff_ffff_8000_0000, 64'h8000_0000_7fff_ffff,
                   64'h7fff_ffff_8000_0000, 64'h7fff_ffff_7fff_ffff,
                   64'h8000_0000_8000_0000, 64'h0000_0000_8000_0000);
        send_sample(32'h7fff_ffff, 32'h8000_0000);
        send_sample(32'h1234_5678, 32'h8765_4321);
        // noise chosen so that S is exactly zero after the first step is primed
        load_coefs(64'h0001_0000_0000_0000, 64'h0000_0000_0001_0000,
                   64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_ffff_0000);
        send_sample(32'h0003_0000, 32'h0);
        send_sample(32'hfffd_0000, 32'h0);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 4)
                load_coefs(64'h0000_0000_ffff_ffff, 64'h0, 64'hffff_ffff_0000_0000,
                           64'h0, 64'h0, 64'h0);
            else if (ph != 0)
                load_coefs({rand_q(17), rand_q(12)}, {rand_q(8), rand_q(17)},
                           {rand_q(14), rand_q(14)}, {rand_q(18), rand_q(10)},
                           {rand_q(10), rand_q(18)}, {32'h0, rand_q(18)});
            if (ph == 2)
            begin
                // hold the receiver off while samples keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (2000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    random_block(6, 20);
                join
            end
            random_block(230, (ph % 2) ? 31 : 20);
            if (ph == 5)
            begin
                drain_results();
                pause = $urandom_range(50, 10);
                repeat (pause) @(posedge clk);
            end
        end

        drain_results();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### kalman_filter_two_state_top.f
rtl/core/kf2_pkg.sv
rtl/core/kf2_if.sv
rtl/core/kf2_datapath.sv
rtl/core/kf2_ctrl.sv
rtl/core/kalman_filter_two_state_top.sv
rtl/core/kf2_checker.sv
tb/kf2_estimate_checker.sv
tb/testbench.sv
